// ===== hw/rtl/usf_pkg.sv =====
`timescale 1ns / 1ps

package usf_pkg;

  // Longest line scanned; later bytes of a line are ignored.
  localparam int MAX_LINE = 65536;
  // Position counter must reach MAX_LINE itself.
  localparam int POS_W = $clog2(MAX_LINE + 1);

  localparam int TEXT_BYTE_W  = 8;
  localparam int URL_START_W  = 16;
  localparam int URL_LENGTH_W = 17;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic letter;
    logic url_char;
    logic colon;
    logic slash;
  } byte_class_t;

  typedef struct packed {
    logic                    emit;
    logic [URL_START_W-1:0]  url_start;
    logic [URL_LENGTH_W-1:0] url_length;
  } scan_result_t;

endpackage

// ===== hw/rtl/usf_if.sv =====
`timescale 1ns / 1ps

interface usf_text_if;
  logic                           valid;
  logic                           ready;
  logic [usf_pkg::TEXT_BYTE_W-1:0] text_byte;
  logic                           line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface usf_span_if;
  logic                            valid;
  logic                            ready;
  logic [usf_pkg::URL_START_W-1:0]  url_start;
  logic [usf_pkg::URL_LENGTH_W-1:0] url_length;

  modport source (output valid, output url_start, output url_length, input ready);
  modport sink   (input valid, input url_start, input url_length, output ready);
endinterface

// ===== hw/rtl/usf_classify.sv =====
`timescale 1ns / 1ps

module usf_classify (
  input  logic [usf_pkg::TEXT_BYTE_W-1:0] text_byte,
  output usf_pkg::byte_class_t            cls
);
  import usf_pkg::*;

  logic letter;
  logic digit;
  logic punct;

  always_comb begin
    letter = 1'b0;
    digit  = 1'b0;
    punct  = 1'b0;
    case (text_byte) inside
      ["a":"z"], ["A":"Z"]: letter = 1'b1;
      ["0":"9"]:            digit  = 1'b1;
      "~", ";", "/", "?", ":", "@", "=", "&", "$", "-",
      "_", ".", "+", "!", "*", "'", "(", ")", ",": punct = 1'b1;
      default: ;
    endcase
  end

  // bytes 128..255 match nothing above
  assign cls.letter   = letter;
  assign cls.url_char = letter | digit | punct;
  assign cls.colon    = (text_byte == ":");
  assign cls.slash    = (text_byte == "/");

endmodule

// ===== hw/rtl/usf_scan.sv =====
`timescale 1ns / 1ps

module usf_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  usf_pkg::byte_class_t   cls,
  input  logic                   line_end,
  output usf_pkg::scan_result_t  res
);
  import usf_pkg::*;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_COLON,
    SEP_ONE_SLASH,
    SEP_FULL
  } sep_phase_t;

  pos_t       char_position,       char_position_next;
  pos_t       letter_run_start,    letter_run_start_next;
  logic       previous_was_letter, previous_was_letter_next;
  sep_phase_t separator_phase,     separator_phase_next;
  pos_t       candidate_start,     candidate_start_next;
  logic       candidate_valid,     candidate_valid_next;
  logic       url_open,            url_open_next;
  pos_t       open_url_start,      open_url_start_next;
  logic       line_overflowed,     line_overflowed_next;
  logic       clear;
  pos_t       span_start;
  pos_t       span_len;

  always_comb begin
    char_position_next       = char_position;
    letter_run_start_next    = letter_run_start;
    previous_was_letter_next = previous_was_letter;
    separator_phase_next     = separator_phase;
    candidate_start_next     = candidate_start;
    candidate_valid_next     = candidate_valid;
    url_open_next            = url_open;
    open_url_start_next      = open_url_start;
    line_overflowed_next     = line_overflowed;
    clear                    = line_end;
    res.emit                 = 1'b0;
    span_start               = open_url_start;
    span_len                 = '0;

    if (line_overflowed) begin
      // rest of an over-long line: nothing but waiting for line_end
    end else if (char_position >= POS_W'(MAX_LINE)) begin
      // first byte past the limit closes any open URL at the limit
      res.emit             = url_open;
      span_len             = POS_W'(MAX_LINE) - open_url_start;
      url_open_next        = 1'b0;
      line_overflowed_next = 1'b1;
    end else begin
      if (url_open) begin
        if (!cls.url_char) begin
          res.emit                 = 1'b1;
          span_len                 = char_position - open_url_start;
          url_open_next            = 1'b0;
          separator_phase_next     = SEP_NONE;
          candidate_valid_next     = 1'b0;
          previous_was_letter_next = 1'b0;
        end
      end else if (separator_phase == SEP_FULL && candidate_valid && cls.url_char) begin
        url_open_next        = 1'b1;
        open_url_start_next  = candidate_start;
        separator_phase_next = SEP_NONE;
        candidate_valid_next = 1'b0;
      end else begin
        if (cls.colon) begin
          candidate_valid_next = previous_was_letter;
          candidate_start_next = previous_was_letter ? letter_run_start : '0;
          separator_phase_next = SEP_COLON;
        end else if (cls.slash && separator_phase == SEP_COLON) begin
          separator_phase_next = SEP_ONE_SLASH;
        end else if (cls.slash && separator_phase == SEP_ONE_SLASH) begin
          separator_phase_next = SEP_FULL;
        end else begin
          separator_phase_next = SEP_NONE;
        end
        if (cls.letter) begin
          if (!previous_was_letter) begin
            letter_run_start_next = char_position;
          end
          previous_was_letter_next = 1'b1;
        end else begin
          previous_was_letter_next = 1'b0;
        end
      end

      if (line_end) begin
        // URL still open at end of line runs through this byte
        if (url_open_next) begin
          res.emit   = 1'b1;
          span_start = open_url_start_next;
          span_len   = char_position + POS_W'(1) - open_url_start_next;
        end
      end else begin
        char_position_next = char_position + POS_W'(1);
      end
    end

    if (clear) begin
      char_position_next       = '0;
      letter_run_start_next    = '0;
      previous_was_letter_next = 1'b0;
      separator_phase_next     = SEP_NONE;
      candidate_start_next     = '0;
      candidate_valid_next     = 1'b0;
      url_open_next            = 1'b0;
      open_url_start_next      = '0;
      line_overflowed_next     = 1'b0;
    end

    res.url_start  = URL_START_W'(span_start);
    res.url_length = URL_LENGTH_W'(span_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position       <= '0;
      letter_run_start    <= '0;
      previous_was_letter <= 1'b0;
      separator_phase     <= SEP_NONE;
      candidate_start     <= '0;
      candidate_valid     <= 1'b0;
      url_open            <= 1'b0;
      open_url_start      <= '0;
      line_overflowed     <= 1'b0;
    end else if (go) begin
      char_position       <= char_position_next;
      letter_run_start    <= letter_run_start_next;
      previous_was_letter <= previous_was_letter_next;
      separator_phase     <= separator_phase_next;
      candidate_start     <= candidate_start_next;
      candidate_valid     <= candidate_valid_next;
      url_open            <= url_open_next;
      open_url_start      <= open_url_start_next;
      line_overflowed     <= line_overflowed_next;
    end
  end

endmodule

// ===== hw/rtl/url_span_finder.sv =====
`timescale 1ns / 1ps

// URL span finder: scans a text line one byte per word and reports each URL
// of the form letters://rest as (url_start, url_length) within the line.
//
// text_in  : valid/ready words of text_byte plus line_end (last byte of line).
// span_out : valid/ready words of url_start (16 bit) and url_length (17 bit),
//            zero or one word per input byte, in line order.
//
// Throughput: one byte per cycle from the single scan stage, while span_out
// takes spans. A byte is first held in the input register; the span it
// closes is loaded into the result register as that byte passes the scan.
//
// When span_out stalls, the result register holds its word; the input
// register keeps taking bytes that produce no span and only blocks on a byte
// that would produce one, so upstream sees back-pressure only then.
//
// Reset (rst, synchronous) empties both registers and returns the scan to
// the start of a line. Bytes past MAX_LINE in a line are ignored; the first
// of them closes an open URL at the limit.
module url_span_finder (
  input  logic       clk,
  input  logic       rst,
  usf_text_if.sink   text_in,
  usf_span_if.source span_out
);
  import usf_pkg::*;

  // input register
  logic                   in_valid;
  logic [TEXT_BYTE_W-1:0] in_byte;
  logic                   in_end;

  // result register
  logic                    out_valid;
  logic [URL_START_W-1:0]  out_start;
  logic [URL_LENGTH_W-1:0] out_length;

  byte_class_t  cls;
  scan_result_t res;
  logic         out_free;
  logic         go;
  logic         take;

  usf_classify u_classify (
    .text_byte (in_byte),
    .cls       (cls)
  );

  usf_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .cls      (cls),
    .line_end (in_end),
    .res      (res)
  );

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid || span_out.ready;
  // byte moves through the scan unless it has a span with nowhere to go
  assign go       = in_valid && (!res.emit || out_free);
  assign take     = text_in.valid && text_in.ready;

  assign text_in.ready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= text_in.text_byte;
      in_end  <= text_in.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && res.emit) begin
      out_valid <= 1'b1;
    end else if (span_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.emit) begin
      out_start  <= res.url_start;
      out_length <= res.url_length;
    end
  end

  assign span_out.valid      = out_valid;
  assign span_out.url_start  = out_start;
  assign span_out.url_length = out_length;

endmodule
